FILE: design/cac_pkg.sv
// Shared operation and status codes for the complex arithmetic unit.
`timescale 1ns / 1ps

package cac_pkg;

   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_GT  = 4'd4;
   localparam logic [3:0] OP_LT  = 4'd5;
   localparam logic [3:0] OP_EQ  = 4'd6;
   localparam logic [3:0] OP_NE  = 4'd7;
   localparam logic [3:0] OP_GE  = 4'd8;
   localparam logic [3:0] OP_LE  = 4'd9;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SAT     = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;
   localparam logic [1:0] ST_BADOP   = 2'd3;

endpackage

FILE: design/complex_arith_and_modulus_compare.sv
// Top level of the complex arithmetic and modulus compare unit.
`timescale 1ns / 1ps

// Takes one transfer per cycle of two complex operands (signed fixed point,
// PART_WIDTH bits with FRAC_BITS fraction bits per part) and an op code, and
// returns one result transfer per item, in order. Add, subtract and multiply
// are exact then truncated toward zero and saturated; divide runs as a chain
// of PART_WIDTH identical restoring-division cells, one quotient bit per cell,
// for both parts at once. Comparisons use exact squared magnitudes. The path
// runs through the input register, product stage, sum stage, setup stage, the
// division chain and the output register; every stage has its own valid
// bit and a ready chain, so bubbles collapse and a new item is taken each
// cycle as long as the result side drains. A zero divisor gives zero with a
// divide-by-zero status; an unknown code gives the bad-op status.
module complex_arith_and_modulus_compare #(
   parameter int PART_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [3:0]                   req_op,
   input  logic signed [PART_WIDTH-1:0] req_a_re,
   input  logic signed [PART_WIDTH-1:0] req_a_im,
   input  logic signed [PART_WIDTH-1:0] req_b_re,
   input  logic signed [PART_WIDTH-1:0] req_b_im,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [PART_WIDTH-1:0] rsp_res_re,
   output logic signed [PART_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_cmp_true,
   output logic [1:0]                   rsp_status
);

   localparam int W  = PART_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int MW = 2 * W;        // product and sum-of-products magnitude
   localparam int RW = 3 * W + F;    // division remainder

   typedef struct packed {
      logic         is_div;
      logic         dz;
      logic         big_re;
      logic         big_im;
      logic         neg_re;
      logic         neg_im;
      logic [W-1:0] res_re;
      logic [W-1:0] res_im;
      logic         cmp;
      logic [1:0]   status;
   } side_type;

   localparam int SIDEW = $bits(side_type);

   // magnitude of a part; the most negative value maps to 2^(W-1)
   function automatic logic [W-1:0] part_mag(input logic signed [W-1:0] x);
      logic signed [W-1:0] n;
      n = -x;
      return x[W-1] ? n : x;
   endfunction

   function automatic logic signed [MW+1:0] signed_prod(input logic neg,
                                                        input logic [MW-1:0] p);
      logic signed [MW+1:0] t;
      t = $signed({2'b00, p});
      return neg ? -t : t;
   endfunction

   // saturate a sign and magnitude to a part: {sat, value}
   function automatic logic [W:0] sat_pack(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] max_pos;
      logic [MW-1:0] max_neg;
      logic [MW-1:0] t;
      logic [W:0]    r;
      max_pos = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
      max_neg = MW'(1) << (W - 1);
      t       = ~mag + MW'(1);
      if (!neg) begin
         if (mag > max_pos) r = {1'b1, 1'b0, {(W-1){1'b1}}};
         else               r = {1'b0, mag[W-1:0]};
      end else begin
         if (mag > max_neg) r = {1'b1, 1'b1, {(W-1){1'b0}}};
         else               r = {1'b0, t[W-1:0]};
      end
      return r;
   endfunction

   // ---------------- input register ----------------
   logic                v0_ff, rdy0;
   logic [3:0]          op0_ff;
   logic signed [W-1:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;

   // ---------------- product stage ----------------
   logic                v1_ff, rdy1;
   logic [3:0]          op1_ff;
   logic [MW-1:0]       p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic [MW-1:0]       p_ar_ff, p_ai_ff, p_br_ff, p_bi_ff;
   logic                n_rr_ff, n_ii_ff, n_ir_ff, n_ri_ff;
   logic signed [W:0]   sum1_re_ff, sum1_im_ff;
   logic [W-1:0]        m_ar, m_ai, m_br, m_bi;
   logic signed [W:0]   sum1_re_in, sum1_im_in;

   // ---------------- sum stage ----------------
   logic                 v2_ff, rdy2;
   logic [3:0]           op2_ff;
   logic signed [MW+1:0] num_re_ff, num_im_ff, num_re_in, num_im_in;
   logic [MW-1:0]        den2_ff, ma2_ff, mb2_ff;
   logic signed [W:0]    sum2_re_ff, sum2_im_ff;
   logic signed [MW+1:0] sp_rr, sp_ii, sp_ir, sp_ri;

   // ---------------- setup stage ----------------
   logic                 v3_ff, rdy3;
   logic [RW-1:0]        rem3_re_ff, rem3_im_ff, rem3_re_in, rem3_im_in;
   logic [MW-1:0]        den3_ff;
   side_type             side3_ff, side3_in;
   logic                 neg_re, neg_im;
   logic signed [MW+1:0] abs_re_s, abs_im_s;
   logic [MW-1:0]        abs_re, abs_im;
   logic [W:0]           add_abs_re, add_abs_im;
   logic [W:0]           pk_mul_re, pk_mul_im, pk_add_re, pk_add_im;
   logic                 cmp3;

   // ---------------- division chain links ----------------
   logic          l_valid [W+1];
   logic          l_ready [W+1];
   logic [RW-1:0] l_rem_re [W+1];
   logic [RW-1:0] l_rem_im [W+1];
   logic [MW-1:0] l_den [W+1];
   logic [W-1:0]  l_q_re [W+1];
   logic [W-1:0]  l_q_im [W+1];
   logic [SIDEW-1:0] l_side [W+1];

   // ---------------- output register ----------------
   logic          rsp_valid_ff, rdy_out;
   logic [W-1:0]  out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic          out_cmp_ff, out_cmp_in;
   logic [1:0]    out_status_ff, out_status_in;
   side_type      side_last;
   logic [MW-1:0] qmag_re, qmag_im;
   logic [W:0]    pk_div_re, pk_div_im;

   // ready chain: a stage takes new data when empty or when it drains
   assign rdy_out    = !rsp_valid_ff || !rsp_stall;
   assign l_ready[W] = rdy_out;
   assign rdy3       = !v3_ff || l_ready[0];
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign rdy0       = !v0_ff || rdy1;
   assign req_stall  = !rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy0)    v0_ff <= req_valid;
         if (rdy1)    v1_ff <= v0_ff;
         if (rdy2)    v2_ff <= v1_ff;
         if (rdy3)    v3_ff <= v2_ff;
         if (rdy_out) rsp_valid_ff <= l_valid[W];
      end
   end

   // hold the operands of an accepted transfer
   always_ff @(posedge clock) begin
      if (rdy0) begin
         op0_ff <= req_op;
         ar0_ff <= req_a_re;
         ai0_ff <= req_a_im;
         br0_ff <= req_b_re;
         bi0_ff <= req_b_im;
      end
   end

   // magnitudes, the eight products, and the add/sub sums
   always_comb begin
      m_ar = part_mag(ar0_ff);
      m_ai = part_mag(ai0_ff);
      m_br = part_mag(br0_ff);
      m_bi = part_mag(bi0_ff);
      if (op0_ff == cac_pkg::OP_SUB) begin
         sum1_re_in = $signed({ar0_ff[W-1], ar0_ff}) - $signed({br0_ff[W-1], br0_ff});
         sum1_im_in = $signed({ai0_ff[W-1], ai0_ff}) - $signed({bi0_ff[W-1], bi0_ff});
      end else begin
         sum1_re_in = $signed({ar0_ff[W-1], ar0_ff}) + $signed({br0_ff[W-1], br0_ff});
         sum1_im_in = $signed({ai0_ff[W-1], ai0_ff}) + $signed({bi0_ff[W-1], bi0_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op1_ff     <= op0_ff;
         p_rr_ff    <= MW'(m_ar) * MW'(m_br);
         p_ii_ff    <= MW'(m_ai) * MW'(m_bi);
         p_ir_ff    <= MW'(m_ai) * MW'(m_br);
         p_ri_ff    <= MW'(m_ar) * MW'(m_bi);
         p_ar_ff    <= MW'(m_ar) * MW'(m_ar);
         p_ai_ff    <= MW'(m_ai) * MW'(m_ai);
         p_br_ff    <= MW'(m_br) * MW'(m_br);
         p_bi_ff    <= MW'(m_bi) * MW'(m_bi);
         n_rr_ff    <= ar0_ff[W-1] ^ br0_ff[W-1];
         n_ii_ff    <= ai0_ff[W-1] ^ bi0_ff[W-1];
         n_ir_ff    <= ai0_ff[W-1] ^ br0_ff[W-1];
         n_ri_ff    <= ar0_ff[W-1] ^ bi0_ff[W-1];
         sum1_re_ff <= sum1_re_in;
         sum1_im_ff <= sum1_im_in;
      end
   end

   // combine products: multiply uses rr-ii / ir+ri, divide uses the conjugate
   always_comb begin
      sp_rr = signed_prod(n_rr_ff, p_rr_ff);
      sp_ii = signed_prod(n_ii_ff, p_ii_ff);
      sp_ir = signed_prod(n_ir_ff, p_ir_ff);
      sp_ri = signed_prod(n_ri_ff, p_ri_ff);
      if (op1_ff == cac_pkg::OP_MUL) begin
         num_re_in = sp_rr - sp_ii;
         num_im_in = sp_ir + sp_ri;
      end else begin
         num_re_in = sp_rr + sp_ii;
         num_im_in = sp_ir - sp_ri;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         op2_ff     <= op1_ff;
         num_re_ff  <= num_re_in;
         num_im_ff  <= num_im_in;
         den2_ff    <= p_br_ff + p_bi_ff;
         ma2_ff     <= p_ar_ff + p_ai_ff;
         mb2_ff     <= p_br_ff + p_bi_ff;
         sum2_re_ff <= sum1_re_ff;
         sum2_im_ff <= sum1_im_ff;
      end
   end

   // settle everything but the quotient; seed the division chain
   always_comb begin
      neg_re     = num_re_ff[MW+1];
      neg_im     = num_im_ff[MW+1];
      abs_re_s   = neg_re ? -num_re_ff : num_re_ff;
      abs_im_s   = neg_im ? -num_im_ff : num_im_ff;
      abs_re     = abs_re_s[MW-1:0];
      abs_im     = abs_im_s[MW-1:0];
      add_abs_re = sum2_re_ff[W] ? (W+1)'(0) - sum2_re_ff : sum2_re_ff;
      add_abs_im = sum2_im_ff[W] ? (W+1)'(0) - sum2_im_ff : sum2_im_ff;
      pk_mul_re  = sat_pack(neg_re, abs_re >> F);
      pk_mul_im  = sat_pack(neg_im, abs_im >> F);
      pk_add_re  = sat_pack(sum2_re_ff[W], MW'(add_abs_re));
      pk_add_im  = sat_pack(sum2_im_ff[W], MW'(add_abs_im));
      rem3_re_in = RW'(abs_re) << F;
      rem3_im_in = RW'(abs_im) << F;

      case (op2_ff)
         cac_pkg::OP_GT: cmp3 = (ma2_ff >  mb2_ff);
         cac_pkg::OP_LT: cmp3 = (ma2_ff <  mb2_ff);
         cac_pkg::OP_EQ: cmp3 = (ma2_ff == mb2_ff);
         cac_pkg::OP_NE: cmp3 = (ma2_ff != mb2_ff);
         cac_pkg::OP_GE: cmp3 = (ma2_ff >= mb2_ff);
         cac_pkg::OP_LE: cmp3 = (ma2_ff <= mb2_ff);
         default:        cmp3 = 1'b0;
      endcase

      side3_in        = '0;
      side3_in.neg_re = neg_re;
      side3_in.neg_im = neg_im;
      // quotient of 2^W or more always saturates
      side3_in.big_re = (rem3_re_in >= (RW'(den2_ff) << W));
      side3_in.big_im = (rem3_im_in >= (RW'(den2_ff) << W));
      side3_in.dz     = (den2_ff == '0);

      case (op2_ff)
         cac_pkg::OP_ADD, cac_pkg::OP_SUB: begin
            side3_in.res_re = pk_add_re[W-1:0];
            side3_in.res_im = pk_add_im[W-1:0];
            side3_in.status = (pk_add_re[W] || pk_add_im[W]) ? cac_pkg::ST_SAT
                                                             : cac_pkg::ST_OK;
         end
         cac_pkg::OP_MUL: begin
            side3_in.res_re = pk_mul_re[W-1:0];
            side3_in.res_im = pk_mul_im[W-1:0];
            side3_in.status = (pk_mul_re[W] || pk_mul_im[W]) ? cac_pkg::ST_SAT
                                                             : cac_pkg::ST_OK;
         end
         cac_pkg::OP_DIV: begin
            side3_in.is_div = 1'b1;
         end
         cac_pkg::OP_GT, cac_pkg::OP_LT, cac_pkg::OP_EQ,
         cac_pkg::OP_NE, cac_pkg::OP_GE, cac_pkg::OP_LE: begin
            side3_in.cmp = cmp3;
         end
         default: begin
            side3_in.status = cac_pkg::ST_BADOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rem3_re_ff <= rem3_re_in;
         rem3_im_ff <= rem3_im_in;
         den3_ff    <= den2_ff;
         side3_ff   <= side3_in;
      end
   end

   assign l_valid[0]  = v3_ff;
   assign l_rem_re[0] = rem3_re_ff;
   assign l_rem_im[0] = rem3_im_ff;
   assign l_den[0]    = den3_ff;
   assign l_q_re[0]   = '0;
   assign l_q_im[0]   = '0;
   assign l_side[0]   = side3_ff;

   // one cell per quotient bit, most significant first
   for (genvar k = 0; k < W; k++) begin : g_cell
      cac_div_cell #(
         .RW    (RW),
         .DW    (MW),
         .QW    (W),
         .SW    (SIDEW),
         .SHIFT (W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (l_valid[k]),
         .up_ready  (l_ready[k]),
         .up_rem_re (l_rem_re[k]),
         .up_rem_im (l_rem_im[k]),
         .up_den    (l_den[k]),
         .up_q_re   (l_q_re[k]),
         .up_q_im   (l_q_im[k]),
         .up_side   (l_side[k]),
         .dn_valid  (l_valid[k+1]),
         .dn_ready  (l_ready[k+1]),
         .dn_rem_re (l_rem_re[k+1]),
         .dn_rem_im (l_rem_im[k+1]),
         .dn_den    (l_den[k+1]),
         .dn_q_re   (l_q_re[k+1]),
         .dn_q_im   (l_q_im[k+1]),
         .dn_side   (l_side[k+1])
      );
   end

   // final selection: quotient for divide, early result otherwise
   always_comb begin
      side_last = side_type'(l_side[W]);
      qmag_re   = side_last.big_re ? (MW'(1) << W) : MW'(l_q_re[W]);
      qmag_im   = side_last.big_im ? (MW'(1) << W) : MW'(l_q_im[W]);
      pk_div_re = sat_pack(side_last.neg_re, qmag_re);
      pk_div_im = sat_pack(side_last.neg_im, qmag_im);
      out_re_in     = side_last.res_re;
      out_im_in     = side_last.res_im;
      out_cmp_in    = side_last.cmp;
      out_status_in = side_last.status;
      if (side_last.is_div) begin
         out_cmp_in = 1'b0;
         if (side_last.dz) begin
            out_re_in     = '0;
            out_im_in     = '0;
            out_status_in = cac_pkg::ST_DIVZERO;
         end else begin
            out_re_in     = pk_div_re[W-1:0];
            out_im_in     = pk_div_im[W-1:0];
            out_status_in = (pk_div_re[W] || pk_div_im[W]) ? cac_pkg::ST_SAT
                                                           : cac_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         out_re_ff     <= out_re_in;
         out_im_ff     <= out_im_in;
         out_cmp_ff    <= out_cmp_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_re   = out_re_ff;
   assign rsp_res_im   = out_im_ff;
   assign rsp_cmp_true = out_cmp_ff;
   assign rsp_status   = out_status_ff;

endmodule

FILE: design/cac_div_cell.sv
// One restoring-division step for the real and imaginary lanes.
`timescale 1ns / 1ps

module cac_div_cell #(
   parameter int RW    = 56,
   parameter int DW    = 32,
   parameter int QW    = 16,
   parameter int SW    = 40,
   parameter int SHIFT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  logic [RW-1:0] up_rem_re,
   input  logic [RW-1:0] up_rem_im,
   input  logic [DW-1:0] up_den,
   input  logic [QW-1:0] up_q_re,
   input  logic [QW-1:0] up_q_im,
   input  logic [SW-1:0] up_side,
   output logic          dn_valid,
   input  logic          dn_ready,
   output logic [RW-1:0] dn_rem_re,
   output logic [RW-1:0] dn_rem_im,
   output logic [DW-1:0] dn_den,
   output logic [QW-1:0] dn_q_re,
   output logic [QW-1:0] dn_q_im,
   output logic [SW-1:0] dn_side
);

   logic          valid_ff;
   logic [RW-1:0] rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] q_re_ff, q_im_ff, q_re_in, q_im_in;
   logic [SW-1:0] side_ff;
   logic [RW-1:0] den_sh;
   logic          ge_re, ge_im;

   assign up_ready = !valid_ff || dn_ready;

   // trial subtract of the divisor at this quotient weight
   always_comb begin
      den_sh    = RW'(up_den) << SHIFT;
      ge_re     = (up_rem_re >= den_sh);
      ge_im     = (up_rem_im >= den_sh);
      rem_re_in = ge_re ? (up_rem_re - den_sh) : up_rem_re;
      rem_im_in = ge_im ? (up_rem_im - den_sh) : up_rem_im;
      q_re_in   = up_q_re;
      q_im_in   = up_q_im;
      q_re_in[SHIFT] = ge_re;
      q_im_in[SHIFT] = ge_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         den_ff    <= up_den;
         q_re_ff   <= q_re_in;
         q_im_ff   <= q_im_in;
         side_ff   <= up_side;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_rem_re = rem_re_ff;
   assign dn_rem_im = rem_im_ff;
   assign dn_den    = den_ff;
   assign dn_q_re   = q_re_ff;
   assign dn_q_im   = q_im_ff;
   assign dn_side   = side_ff;

endmodule

FILE: design/cac_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module cac_checker #(
   parameter int PART_WIDTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PART_WIDTH-1:0] rsp_res_re,
   input logic [PART_WIDTH-1:0] rsp_res_im,
   input logic                  rsp_cmp_true,
   input logic [1:0]            rsp_status
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_res_re) && $stable(rsp_res_im)
                                 && $stable(rsp_status) && $stable(rsp_cmp_true))
      else $error("stalled result changed");

   a_badop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cac_pkg::ST_BADOP
         |-> rsp_res_re == '0 && rsp_res_im == '0 && !rsp_cmp_true)
      else $error("bad op result not cleared");

   a_divzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cac_pkg::ST_DIVZERO
         |-> rsp_res_re == '0 && rsp_res_im == '0 && !rsp_cmp_true)
      else $error("divide by zero result not cleared");

   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmp_true
         |-> rsp_status == cac_pkg::ST_OK && rsp_res_re == '0 && rsp_res_im == '0)
      else $error("comparison result carries arithmetic data");

endmodule

bind complex_arith_and_modulus_compare cac_checker #(
   .PART_WIDTH (PART_WIDTH)
) u_cac_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_res_re   (rsp_res_re),
   .rsp_res_im   (rsp_res_im),
   .rsp_cmp_true (rsp_cmp_true),
   .rsp_status   (rsp_status)
);

FILE: bench/tb_complex_arith_and_modulus_compare.sv
// Self-checking testbench for the complex arithmetic and modulus compare unit.
`timescale 1ns / 1ps

module tb_complex_arith_and_modulus_compare;

   localparam int W        = 16;
   localparam int FRAC     = 8;
   localparam int N_RANDOM = 1400;
   // Pipeline depth plus margin for the drain.
   localparam int DRAIN    = W + 5 + 20;

   typedef struct packed {
      logic [3:0]          op;
      logic signed [W-1:0] a_re;
      logic signed [W-1:0] a_im;
      logic signed [W-1:0] b_re;
      logic signed [W-1:0] b_im;
   } operands_type;

   typedef struct packed {
      logic signed [W-1:0] res_re;
      logic signed [W-1:0] res_im;
      logic                cmp_true;
      logic [1:0]          status;
   } outcome_type;

   // Scoreboard: computes the expected outcome of each accepted operand transfer
   // and checks result transfers against them in order.
   class complex_scoreboard;
      outcome_type pending[$];
      int          fails = 0;

      // Reduce an exact value to the part format, saturating.
      function automatic logic [W-1:0] clamp(longint v, ref logic sat);
         longint hi, lo;
         hi = (64'sd1 <<< (W - 1)) - 1;
         lo = -(64'sd1 <<< (W - 1));
         if (v > hi) begin
            sat = 1'b1;
            return hi[W-1:0];
         end
         if (v < lo) begin
            sat = 1'b1;
            return lo[W-1:0];
         end
         return v[W-1:0];
      endfunction

      // Drop the fraction bits of a product, truncating toward zero.
      function automatic longint drop_frac(longint v);
         return (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
      endfunction

      // Scaled quotient num * 2^FRAC / den, truncated toward zero; den > 0.
      function automatic longint scaled_quot(longint num, longint den);
         longint mag;
         mag = (num < 0) ? -num : num;
         mag = (mag <<< FRAC) / den;
         return (num < 0) ? -mag : mag;
      endfunction

      function automatic outcome_type compute(operands_type x);
         longint      ar, ai, br, bi, vr, vi, den, ma, mb;
         logic        sat;
         logic        c;
         outcome_type o;
         ar = x.a_re;
         ai = x.a_im;
         br = x.b_re;
         bi = x.b_im;
         o = '0;
         sat = 1'b0;
         c = 1'b0;
         vr = 0;
         vi = 0;
         ma = ar * ar + ai * ai;
         mb = br * br + bi * bi;
         case (x.op)
            cac_pkg::OP_ADD, cac_pkg::OP_SUB, cac_pkg::OP_MUL, cac_pkg::OP_DIV: begin
               if (x.op == cac_pkg::OP_ADD) begin
                  vr = ar + br;
                  vi = ai + bi;
               end else if (x.op == cac_pkg::OP_SUB) begin
                  vr = ar - br;
                  vi = ai - bi;
               end else if (x.op == cac_pkg::OP_MUL) begin
                  vr = drop_frac(ar * br - ai * bi);
                  vi = drop_frac(ai * br + ar * bi);
               end else begin
                  den = mb;
                  if (den != 0) begin
                     vr = scaled_quot(ar * br + ai * bi, den);
                     vi = scaled_quot(ai * br - ar * bi, den);
                  end
               end
               if (x.op == cac_pkg::OP_DIV && mb == 0) begin
                  o.status = cac_pkg::ST_DIVZERO;
               end else begin
                  o.res_re = clamp(vr, sat);
                  o.res_im = clamp(vi, sat);
                  o.status = sat ? cac_pkg::ST_SAT : cac_pkg::ST_OK;
               end
            end
            cac_pkg::OP_GT: c = ma > mb;
            cac_pkg::OP_LT: c = ma < mb;
            cac_pkg::OP_EQ: c = ma == mb;
            cac_pkg::OP_NE: c = ma != mb;
            cac_pkg::OP_GE: c = ma >= mb;
            cac_pkg::OP_LE: c = ma <= mb;
            default: o.status = cac_pkg::ST_BADOP;
         endcase
         o.cmp_true = c;
         return o;
      endfunction

      function void note_operands(operands_type x);
         pending.push_back(compute(x));
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (pending.size() == 0) begin
            $error("result transfer with nothing pending: re=%0d im=%0d cmp=%0d st=%0d",
                   got.res_re, got.res_im, got.cmp_true, got.status);
            fails++;
            return;
         end
         want = pending.pop_front();
         if (got.res_re !== want.res_re) begin
            $error("res_re: expected %0d, actual %0d", want.res_re, got.res_re);
            fails++;
         end
         if (got.res_im !== want.res_im) begin
            $error("res_im: expected %0d, actual %0d", want.res_im, got.res_im);
            fails++;
         end
         if (got.cmp_true !== want.cmp_true) begin
            $error("cmp_true: expected %0d, actual %0d", want.cmp_true, got.cmp_true);
            fails++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fails++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [3:0]          req_op = '0;
   logic signed [W-1:0] req_a_re = '0;
   logic signed [W-1:0] req_a_im = '0;
   logic signed [W-1:0] req_b_re = '0;
   logic signed [W-1:0] req_b_im = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [W-1:0] rsp_res_re;
   logic signed [W-1:0] rsp_res_im;
   logic                rsp_cmp_true;
   logic [1:0]          rsp_status;

   complex_scoreboard sb = new();

   // Burst shaping for the sender: bursts of back-to-back transfers, then usually a gap.
   int burst_left = 0;
   // Receiver stall pattern: a mode picked afresh each time the tick counter wraps.
   int stall_mode = 0;
   int stall_tick = 0;

   complex_arith_and_modulus_compare #(.PART_WIDTH(W), .FRAC_BITS(FRAC)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_a_re     (req_a_re),
      .req_a_im     (req_a_im),
      .req_b_re     (req_b_re),
      .req_b_im     (req_b_im),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_cmp_true (rsp_cmp_true),
      .rsp_status   (rsp_status)
   );

   always #6 clock = ~clock;

   // Receiver: hold stall on a pattern of its own, including long clear stretches.
   always @(posedge clock) begin
      if (stall_tick == 0) begin
         stall_mode <= $urandom_range(0, 3);
      end
      stall_tick <= (stall_tick + 1) % 64;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 0);
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= ((stall_tick % 5) == 0);
      endcase
   end

   // Monitors: sample at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_operands('{req_op, req_a_re, req_a_im, req_b_re, req_b_im});
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_outcome('{rsp_res_re, rsp_res_im, rsp_cmp_true, rsp_status});
      end
   end

   // Present one operand set and hold it until the transfer happens; then
   // advance the burst and drop valid only when a gap follows.
   task automatic send_operands(logic [3:0] op, logic [W-1:0] ar, logic [W-1:0] ai,
                                logic [W-1:0] br, logic [W-1:0] bi);
      int gap;
      req_valid <= 1'b1;
      req_op    <= op;
      req_a_re  <= ar;
      req_a_im  <= ai;
      req_b_re  <= br;
      req_b_im  <= bi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Operand part: mostly full random, some extremes and small values.
   function automatic logic [W-1:0] pick_part();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return '0;
         3: return W'($urandom_range(0, 512) - 256);
         4: return W'($urandom_range(0, 8) - 4);
         default: return W'($urandom);
      endcase
   endfunction

   initial begin
      logic [3:0]   op;
      logic [W-1:0] ar, ai, br, bi;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every op on extremes, saturation, zero divisor, equal moduli.
      send_operands(cac_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_operands(cac_pkg::OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
      send_operands(cac_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_operands(cac_pkg::OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
      send_operands(cac_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_operands(cac_pkg::OP_MUL, 16'h0100, 16'h0000, 16'hff01, 16'h00ff);
      send_operands(cac_pkg::OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
      send_operands(cac_pkg::OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
      send_operands(cac_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
      send_operands(cac_pkg::OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
      send_operands(cac_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h8000, 16'h7fff);
      send_operands(cac_pkg::OP_GT,  16'h0300, 16'h0400, 16'h0500, 16'h0000);
      send_operands(cac_pkg::OP_LT,  16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      send_operands(cac_pkg::OP_EQ,  16'h0300, 16'h0400, 16'hfb00, 16'h0000);
      send_operands(cac_pkg::OP_NE,  16'h0300, 16'h0400, 16'h0000, 16'h0500);
      send_operands(cac_pkg::OP_GE,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_operands(cac_pkg::OP_LE,  16'h8000, 16'h0000, 16'h0000, 16'h8000);
      for (int k = 10; k < 16; k++) begin
         send_operands(k[3:0], 16'h8000, 16'h7fff, 16'h1234, 16'hedcb);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
         ar = pick_part();
         ai = pick_part();
         br = pick_part();
         bi = pick_part();
         // Force some equal moduli and zero divisors into the mix.
         if ($urandom_range(0, 9) == 0) begin
            br = ($urandom_range(0, 1) == 0) ? ai : -ar;
            bi = ar;
         end
         if (op == cac_pkg::OP_DIV && $urandom_range(0, 11) == 0) begin
            br = '0;
            bi = '0;
         end
         send_operands(op, ar, ai, br, bi);
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.fails == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
design/cac_pkg.sv
design/cac_div_cell.sv
design/complex_arith_and_modulus_compare.sv
design/cac_checker.sv
bench/tb_complex_arith_and_modulus_compare.sv
